>>> rtl/core/gbfs_pkg.sv
package gbfs_pkg;

    // request codes
    localparam logic CMD_WALL   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // configuration register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // move directions, in the order neighbours are tried
    localparam logic [1:0] DIR_E = 2'd0;
    localparam logic [1:0] DIR_S = 2'd1;
    localparam logic [1:0] DIR_W = 2'd2;
    localparam logic [1:0] DIR_N = 2'd3;

    // most moves reported for one search
    localparam logic [5:0] RESULT_LIMIT = 6'd63;

    localparam logic [3:0] DIM_RESET = 4'd8;

endpackage

>>> rtl/core/grid_bfs_shortest_path.sv
// channel   direction  ports                                   accepted when
// s_        in         command, cell/start/target coordinates  s_valid && s_ready
// m_        out        found, path_length, step_number, dir    m_valid && m_ready
// cfg_      in         index (0 rows, 1 cols), 4-bit data      cfg_valid && cfg_ready
//
// after reset a clearing pass over every cell empties the wall and visited maps
// a search clears the visited map over every cell and seeds the queue with the start cell,
// then dequeues cells and tries the directions of each in E, S, W, N order, reading the
// wall and visited maps at each in-range neighbour (one write and one read port each)
// the trace back walks parent entries into the path memory; each result waits for m_ready
// one request is worked at a time; s_ready is low until the last result is taken
module grid_bfs_shortest_path
    import gbfs_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [2:0] s_cell_row,
    input  logic [2:0] s_cell_col,
    input  logic       s_wall_bit,
    input  logic [2:0] s_start_row,
    input  logic [2:0] s_start_col,
    input  logic [2:0] s_target_row,
    input  logic [2:0] s_target_col,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_found,
    output logic [5:0] m_path_length,
    output logic [5:0] m_step_number,
    output logic [1:0] m_move_dir,
    output logic       m_last_move,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RB    = $clog2(MAX_ROWS + 1);
    localparam int CB    = $clog2(MAX_COLS + 1);
    localparam int LW    = (CW > 6) ? CW : 6;

    typedef struct packed {
        logic [RB-1:0] row;
        logic [CB-1:0] col;
        logic [CW-1:0] parent;
        logic [1:0]    dir;
        logic [CW-1:0] depth;
    } qent_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_VCLR, S_SEED, S_POP, S_CELL, S_NBRD, S_NBEV,
        S_TRRD, S_TRWR, S_PRD, S_PLD, S_OUT
    } state_t;

    function automatic logic [CW-1:0] cell_addr(input logic [RB-1:0] r,
                                                input logic [CB-1:0] c);
        cell_addr = CW'(CW'(r) * CW'(MAX_COLS) + CW'(c));
    endfunction

    state_t        state_reg, state_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [3:0]    rows_reg, cols_reg;
    logic [RB-1:0] nr_reg, nr_next, sr_reg, sr_next, tr_reg, tr_next;
    logic [CB-1:0] nc_reg, nc_next, sc_reg, sc_next, tc_reg, tc_next;
    logic [CW:0]   head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] here_reg, here_next;
    logic [RB-1:0] cur_row_reg, cur_row_next, nb_row_reg, nb_row_next;
    logic [CB-1:0] cur_col_reg, cur_col_next, nb_col_reg, nb_col_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic [1:0]    dir_reg, dir_next;
    logic [CW-1:0] j_reg, j_next, pos_reg, pos_next;
    logic [5:0]    n_reg, n_next, k_reg, k_next;
    logic          m_valid_reg, m_valid_next, m_found_reg, m_found_next;
    logic [5:0]    m_len_reg, m_len_next, m_step_reg, m_step_next;
    logic [1:0]    m_dir_reg, m_dir_next;
    logic          m_last_reg, m_last_next;

    // memories and their ports
    logic          wall_mem [CELLS];
    logic          vis_mem  [CELLS];
    qent_t         q_mem    [CELLS];
    logic [1:0]    path_mem [CELLS];
    logic          wall_we, wall_wd, vis_we, vis_wd, q_we, path_we;
    logic [CW-1:0] wall_wa, vis_wa, nb_ra, q_wa, q_ra, path_wa, path_ra;
    qent_t         q_wd;
    logic [1:0]    path_wd;
    logic          wall_rd_reg, vis_rd_reg;
    qent_t         q_rd_reg;
    logic [1:0]    path_rd_reg;

    // combinational helpers
    logic [7:0]    rows8, cols8, nr8, nc8;
    logic          in_range, nb_ok;
    logic [RB-1:0] nbr;
    logic [CB-1:0] nbc;
    logic [CW-1:0] new_depth;
    logic [LW-1:0] lenx;

    assign s_ready       = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_path_length = m_len_reg;
    assign m_step_number = m_step_reg;
    assign m_move_dir    = m_dir_reg;
    assign m_last_move   = m_last_reg;

    // region size, clamped to 1..maximum
    always_comb begin
        rows8 = 8'(rows_reg);
        cols8 = 8'(cols_reg);
        if (rows8 == 8'd0) nr8 = 8'd1;
        else if (rows8 > 8'(MAX_ROWS)) nr8 = 8'(MAX_ROWS);
        else nr8 = rows8;
        if (cols8 == 8'd0) nc8 = 8'd1;
        else if (cols8 > 8'(MAX_COLS)) nc8 = 8'(MAX_COLS);
        else nc8 = cols8;
        in_range = (8'(s_start_row) < nr8) && (8'(s_start_col) < nc8)
                && (8'(s_target_row) < nr8) && (8'(s_target_col) < nc8);
    end

    // neighbour of the current cell in direction dir_reg
    always_comb begin
        nbr   = cur_row_reg;
        nbc   = cur_col_reg;
        nb_ok = 1'b0;
        unique case (dir_reg)
            DIR_E: begin
                nbc   = cur_col_reg + CB'(1);
                nb_ok = (cur_col_reg + CB'(1)) < nc_reg;
            end
            DIR_S: begin
                nbr   = cur_row_reg + RB'(1);
                nb_ok = (cur_row_reg + RB'(1)) < nr_reg;
            end
            DIR_W: begin
                nbc   = cur_col_reg - CB'(1);
                nb_ok = (cur_col_reg != '0);
            end
            DIR_N: begin
                nbr   = cur_row_reg - RB'(1);
                nb_ok = (cur_row_reg != '0);
            end
            default: nb_ok = 1'b0;
        endcase
    end

    assign new_depth = depth_reg + CW'(1);
    assign lenx      = LW'(new_depth);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        nr_next      = nr_reg;
        nc_next      = nc_reg;
        sr_next      = sr_reg;
        sc_next      = sc_reg;
        tr_next      = tr_reg;
        tc_next      = tc_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        here_next    = here_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        nb_row_next  = nb_row_reg;
        nb_col_next  = nb_col_reg;
        depth_next   = depth_reg;
        dir_next     = dir_reg;
        j_next       = j_reg;
        pos_next     = pos_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_len_next   = m_len_reg;
        m_step_next  = m_step_reg;
        m_dir_next   = m_dir_reg;
        m_last_next  = m_last_reg;
        wall_we      = 1'b0;
        wall_wa      = clr_reg;
        wall_wd      = 1'b0;
        vis_we       = 1'b0;
        vis_wa       = clr_reg;
        vis_wd       = 1'b0;
        nb_ra        = cell_addr(nbr, nbc);
        q_we         = 1'b0;
        q_wa         = tail_reg[CW-1:0];
        q_wd         = '{row: nbr, col: nbc, parent: here_reg, dir: dir_reg,
                         depth: new_depth};
        q_ra         = head_reg[CW-1:0];
        path_we      = 1'b0;
        path_wa      = pos_reg;
        path_wd      = q_rd_reg.dir;
        path_ra      = CW'(k_reg);

        unique case (state_reg)
            S_INIT: begin
                wall_we = 1'b1;
                vis_we  = 1'b1;
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(CELLS - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (s_command == CMD_WALL) begin
                        if (8'(s_cell_row) < 8'(MAX_ROWS) && 8'(s_cell_col) < 8'(MAX_COLS))
                        begin
                            wall_we = 1'b1;
                            wall_wa = cell_addr(RB'(s_cell_row), CB'(s_cell_col));
                            wall_wd = s_wall_bit;
                        end
                    end else if (!in_range
                            || (s_start_row == s_target_row && s_start_col == s_target_col))
                    begin
                        m_valid_next = 1'b1;
                        m_found_next = in_range;
                        m_len_next   = '0;
                        m_step_next  = '0;
                        m_dir_next   = DIR_E;
                        m_last_next  = 1'b1;
                        state_next   = S_OUT;
                    end else begin
                        nr_next    = RB'(nr8);
                        nc_next    = CB'(nc8);
                        sr_next    = RB'(s_start_row);
                        sc_next    = CB'(s_start_col);
                        tr_next    = RB'(s_target_row);
                        tc_next    = CB'(s_target_col);
                        clr_next   = '0;
                        state_next = S_VCLR;
                    end
                end
            end
            S_VCLR: begin
                vis_we   = 1'b1;
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(CELLS - 1)) state_next = S_SEED;
            end
            S_SEED: begin
                vis_we     = 1'b1;
                vis_wa     = cell_addr(sr_reg, sc_reg);
                vis_wd     = 1'b1;
                q_we       = 1'b1;
                q_wa       = '0;
                q_wd       = '{row: sr_reg, col: sc_reg, parent: '0, dir: DIR_E,
                               depth: '0};
                head_next  = '0;
                tail_next  = (CW+1)'(1);
                state_next = S_POP;
            end
            S_POP: begin
                if (head_reg == tail_reg) begin
                    m_valid_next = 1'b1;
                    m_found_next = 1'b0;
                    m_len_next   = '0;
                    m_step_next  = '0;
                    m_dir_next   = DIR_E;
                    m_last_next  = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    here_next  = head_reg[CW-1:0];
                    head_next  = head_reg + (CW+1)'(1);
                    state_next = S_CELL;
                end
            end
            S_CELL: begin
                cur_row_next = q_rd_reg.row;
                cur_col_next = q_rd_reg.col;
                depth_next   = q_rd_reg.depth;
                dir_next     = DIR_E;
                state_next   = S_NBRD;
            end
            S_NBRD: begin
                if (nb_ok) begin
                    nb_row_next = nbr;
                    nb_col_next = nbc;
                    state_next  = S_NBEV;
                end else if (dir_reg == DIR_N) begin
                    state_next = S_POP;
                end else begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            S_NBEV: begin
                q_wd = '{row: nb_row_reg, col: nb_col_reg, parent: here_reg,
                         dir: dir_reg, depth: new_depth};
                if (!vis_rd_reg && !wall_rd_reg && tail_reg < (CW+1)'(CELLS)) begin
                    vis_we    = 1'b1;
                    vis_wa    = cell_addr(nb_row_reg, nb_col_reg);
                    vis_wd    = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + (CW+1)'(1);
                end
                if (!vis_rd_reg && !wall_rd_reg && tail_reg < (CW+1)'(CELLS)
                        && nb_row_reg == tr_reg && nb_col_reg == tc_reg) begin
                    // target entry gives the last move; walk parents for the rest
                    path_we    = 1'b1;
                    path_wa    = depth_reg;
                    path_wd    = dir_reg;
                    pos_next   = depth_reg;
                    j_next     = here_reg;
                    n_next     = (lenx > LW'(RESULT_LIMIT)) ? RESULT_LIMIT : 6'(lenx);
                    k_next     = '0;
                    state_next = (here_reg == '0) ? S_PRD : S_TRRD;
                end else if (dir_reg == DIR_N) begin
                    state_next = S_POP;
                end else begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = S_NBRD;
                end
            end
            S_TRRD: begin
                q_ra       = j_reg;
                state_next = S_TRWR;
            end
            S_TRWR: begin
                path_we    = 1'b1;
                path_wa    = pos_reg - CW'(1);
                pos_next   = pos_reg - CW'(1);
                j_next     = q_rd_reg.parent;
                state_next = (q_rd_reg.parent == '0) ? S_PRD : S_TRRD;
            end
            S_PRD: begin
                state_next = S_PLD;
            end
            S_PLD: begin
                m_valid_next = 1'b1;
                m_found_next = 1'b1;
                m_len_next   = n_reg;
                m_step_next  = k_reg;
                m_dir_next   = path_rd_reg;
                m_last_next  = (k_reg == n_reg - 6'd1);
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    k_next       = k_reg + 6'd1;
                    state_next   = m_last_reg ? S_IDLE : S_PRD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            clr_reg     <= '0;
            rows_reg    <= DIM_RESET;
            cols_reg    <= DIM_RESET;
            head_reg    <= '0;
            tail_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_index == REG_ROWS) rows_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_COLS) cols_reg <= cfg_data;
        end
        nr_reg      <= nr_next;
        nc_reg      <= nc_next;
        sr_reg      <= sr_next;
        sc_reg      <= sc_next;
        tr_reg      <= tr_next;
        tc_reg      <= tc_next;
        here_reg    <= here_next;
        cur_row_reg <= cur_row_next;
        cur_col_reg <= cur_col_next;
        nb_row_reg  <= nb_row_next;
        nb_col_reg  <= nb_col_next;
        depth_reg   <= depth_next;
        dir_reg     <= dir_next;
        j_reg       <= j_next;
        pos_reg     <= pos_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        m_found_reg <= m_found_next;
        m_len_reg   <= m_len_next;
        m_step_reg  <= m_step_next;
        m_dir_reg   <= m_dir_next;
        m_last_reg  <= m_last_next;
    end

    // wall and visited maps, read at the neighbour cell
    always_ff @(posedge aclk) begin
        if (wall_we) wall_mem[wall_wa] <= wall_wd;
        wall_rd_reg <= wall_mem[nb_ra];
    end

    always_ff @(posedge aclk) begin
        if (vis_we) vis_mem[vis_wa] <= vis_wd;
        vis_rd_reg <= vis_mem[nb_ra];
    end

    // search queue: cell, parent entry, arrival move and depth
    always_ff @(posedge aclk) begin
        if (q_we) q_mem[q_wa] <= q_wd;
        q_rd_reg <= q_mem[q_ra];
    end

    // moves of the found path, in order from the start
    always_ff @(posedge aclk) begin
        if (path_we) path_mem[path_wa] <= path_wd;
        path_rd_reg <= path_mem[path_ra];
    end

    // checks
    a_head_le_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_tail_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg <= (CW+1)'(CELLS))
        else $error("queue tail beyond depth");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while a result is pending");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_move) |=> (state_reg == S_IDLE))
        else $error("final result did not end the search");

endmodule
